// ===== hdl/json_string_escaper_utf8_core_defines.svh =====
// Assertion macros shared by the escaper RTL.
`ifndef JSON_STRING_ESCAPER_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_ESCAPER_UTF8_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSE_ASSERT_NOW(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSE_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/jse_pkg.sv =====
`timescale 1ns / 1ps

package jse_pkg;

   // Item kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_NULL = 2'd2;

   // Characters of the JSON text
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_L      = 8'h6c;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;

   // Control bytes with short escapes
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_HT = 8'h09;
   localparam logic [7:0] CTL_LF = 8'h0a;
   localparam logic [7:0] CTL_FF = 8'h0c;
   localparam logic [7:0] CTL_CR = 8'h0d;
   localparam logic [7:0] CTL_LIMIT   = 8'h20;
   localparam logic [7:0] ASCII_LIMIT = 8'h80;

   // UTF-8 lead byte ranges
   localparam logic [7:0] LEAD2_LO = 8'hc2;
   localparam logic [7:0] LEAD2_HI = 8'hdf;
   localparam logic [7:0] LEAD3_LO = 8'he0;
   localparam logic [7:0] LEAD3_HI = 8'hef;
   localparam logic [7:0] LEAD4_LO = 8'hf0;
   localparam logic [7:0] LEAD4_HI = 8'hf4;

   // Code point limits
   localparam logic [20:0] CP_MIN3      = 21'h000800;
   localparam logic [20:0] CP_MIN4      = 21'h010000;
   localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
   localparam logic [20:0] CP_SURR_HI   = 21'h00dfff;
   localparam logic [20:0] CP_MAX       = 21'h10ffff;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned HELD_MAX = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       string_done;
   } rsp_type;

   typedef enum logic [2:0] {
      TAIL_NONE,
      TAIL_RAW,
      TAIL_ESC,
      TAIL_HEX,
      TAIL_CLOSE,
      TAIL_NULL
   } tail_type;

   // One classified item: optional opening quote, held bytes, then a tail.
   typedef struct packed {
      logic                          open_quote;
      logic [HELD_MAX-1:0][7:0]      held;
      logic [1:0]                    held_n;
      logic                          held_hex;
      tail_type                      tail;
      logic [7:0]                    tail_byte;
   } cmd_type;

   function automatic logic [2:0] tail_len(input tail_type t);
      case (t)
         TAIL_RAW:   tail_len = 3'd1;
         TAIL_ESC:   tail_len = 3'd2;
         TAIL_HEX:   tail_len = 3'd6;
         TAIL_CLOSE: tail_len = 3'd1;
         TAIL_NULL:  tail_len = 3'd4;
         default:    tail_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib < 4'd10) begin
         hex_digit = CH_ZERO + {4'd0, nib};
      end else begin
         hex_digit = 8'h57 + {4'd0, nib};
      end
   endfunction

   // Character at position sub (0..5) of the \u00xx form of b.
   function automatic logic [7:0] hex_char(input logic [7:0] b, input logic [2:0] sub);
      case (sub)
         3'd0:    hex_char = CH_BSLASH;
         3'd1:    hex_char = CH_U;
         3'd2:    hex_char = CH_ZERO;
         3'd3:    hex_char = CH_ZERO;
         3'd4:    hex_char = hex_digit(b[7:4]);
         default: hex_char = hex_digit(b[3:0]);
      endcase
   endfunction

endpackage

// ===== hdl/json_string_escaper_utf8_core.sv =====
// Channel   Ports                        Direction  Transfer when
// -------   --------------------------   ---------  ----------------------
// request   push, full, req_data         in         push && !full
// response  empty, pop, rsp_data         out        pop && !empty
//
// One output byte per cycle while the consumer keeps popping; an item produces
// 1 to 24 bytes, and items that only buffer a UTF-8 byte or are dropped produce
// nothing. The first byte passes through the command queue and then the output
// register before it reaches rsp_data. A two-entry command queue sits
// between classifier and byte sequencer; full rises when both entries wait.
// Reset is synchronous, active high, and clears control state but not the sequencer phase/indices.
`timescale 1ns / 1ps
`include "json_string_escaper_utf8_core_defines.svh"

module json_string_escaper_utf8_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  jse_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output jse_pkg::rsp_type  rsp_data
);

   // Command handoff between classifier and sequencer
   logic              accept;
   logic              cmd_valid;
   jse_pkg::cmd_type  cmd;
   jse_pkg::cmd_type  q_head;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic              rsp_valid;

   // Terms used by the checks below
   logic              end_accept;
   logic              close_out;

   // Accept whenever the queue has room; items that produce nothing skip it.
   assign full   = q_full;
   assign accept = push && !q_full;
   assign empty  = !rsp_valid;

   // Classify: track open string and pending UTF-8 sequence, build a command.
   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   // Hold up to two commands so classification and byte output stall apart.
   jse_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (cmd_valid),
      .wr_cmd (cmd),
      .rd_en  (q_pop),
      .rd_cmd (q_head),
      .full   (q_full),
      .empty  (q_empty)
   );

   // Expand the head command into bytes, one per cycle while the output register is free or popped.
   jse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (q_head),
      .head_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_data),
      .rsp_pop    (pop)
   );

   assign end_accept = accept && (req_data.kind == jse_pkg::KIND_END);
   assign close_out  = !empty && rsp_data.string_done;

   // An end marker always leaves a command behind.
   `JSE_ASSERT_NEXT(a_end_queued, clock, reset, end_accept, !q_empty, "end left no command")
   // The sequencer retires only commands that exist.
   `JSE_ASSERT_NOW(a_pop_has_head, clock, reset, q_pop, !q_empty, "queue popped while empty")
   // A waiting command fills an empty output register on the next edge.
   `JSE_ASSERT_NEXT(a_head_drains, clock, reset, !q_empty && empty, !empty, "output not loaded")
   // A closing byte always ends its run.
   `JSE_ASSERT_NOW(a_done_is_last, clock, reset, close_out, rsp_data.last_of_run, "done not last")

endmodule

// ===== hdl/jse_front.sv =====
`timescale 1ns / 1ps

module jse_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  jse_pkg::req_type  req,
   output logic              cmd_valid,
   output jse_pkg::cmd_type  cmd
);

   logic                              open_ff, open_in;
   logic [jse_pkg::HELD_MAX-1:0][7:0] held_ff, held_in;
   logic [1:0]                        held_cnt_ff, held_cnt_in;
   logic [2:0]                        seq_len_ff, seq_len_in;
   logic [20:0]                       acc_ff, acc_in;

   logic [7:0]  b;
   logic [7:0]  esc;
   logic [20:0] cp;
   logic        cont;
   logic        complete;
   logic        bad;

   always_comb begin
      b        = req.in_byte;
      cont     = (b[7:6] == 2'b10);
      cp       = {acc_ff[14:0], b[5:0]};
      complete = (({1'b0, held_cnt_ff} + 3'd1) >= seq_len_ff);
      bad      = ((seq_len_ff == 3'd3) && (cp < jse_pkg::CP_MIN3)) ||
                 ((seq_len_ff == 3'd4) && (cp < jse_pkg::CP_MIN4)) ||
                 ((cp >= jse_pkg::CP_SURR_LO) && (cp <= jse_pkg::CP_SURR_HI)) ||
                 (cp > jse_pkg::CP_MAX);
      esc      = 8'h00;

      cmd           = '0;
      cmd.held      = held_ff;
      cmd.tail      = jse_pkg::TAIL_NONE;
      cmd.tail_byte = b;

      open_in     = open_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      seq_len_in  = seq_len_ff;
      acc_in      = acc_ff;

      if (accept) begin
         case (req.kind)
            jse_pkg::KIND_BYTE: begin
               cmd.open_quote = !open_ff;
               open_in        = 1'b1;
               if ((held_cnt_ff != 2'd0) && cont) begin
                  if (complete || (held_cnt_ff == 2'd3)) begin
                     cmd.held_n   = held_cnt_ff;
                     cmd.held_hex = !complete || bad;
                     cmd.tail     = (!complete || bad) ? jse_pkg::TAIL_HEX : jse_pkg::TAIL_RAW;
                     held_cnt_in  = 2'd0;
                     seq_len_in   = 3'd0;
                     acc_in       = '0;
                  end else begin
                     held_in[held_cnt_ff] = b;
                     held_cnt_in          = held_cnt_ff + 2'd1;
                     acc_in               = cp;
                  end
               end else begin
                  // flush a broken sequence, then treat b as fresh
                  cmd.held_n   = held_cnt_ff;
                  cmd.held_hex = 1'b1;
                  held_cnt_in  = 2'd0;
                  seq_len_in   = 3'd0;
                  acc_in       = '0;
                  case (b)
                     jse_pkg::CH_QUOTE:  esc = jse_pkg::CH_QUOTE;
                     jse_pkg::CH_BSLASH: esc = jse_pkg::CH_BSLASH;
                     jse_pkg::CTL_BS:    esc = jse_pkg::CH_B;
                     jse_pkg::CTL_FF:    esc = jse_pkg::CH_F;
                     jse_pkg::CTL_LF:    esc = jse_pkg::CH_N;
                     jse_pkg::CTL_CR:    esc = jse_pkg::CH_R;
                     jse_pkg::CTL_HT:    esc = jse_pkg::CH_T;
                     default:            esc = 8'h00;
                  endcase
                  if (esc != 8'h00) begin
                     cmd.tail      = jse_pkg::TAIL_ESC;
                     cmd.tail_byte = esc;
                  end else if (b < jse_pkg::CTL_LIMIT) begin
                     cmd.tail = jse_pkg::TAIL_HEX;
                  end else if (b < jse_pkg::ASCII_LIMIT) begin
                     cmd.tail = jse_pkg::TAIL_RAW;
                  end else if (b inside {[jse_pkg::LEAD2_LO:jse_pkg::LEAD2_HI]}) begin
                     held_in[0]  = b;
                     held_cnt_in = 2'd1;
                     seq_len_in  = 3'd2;
                     acc_in      = {16'd0, b[4:0]};
                  end else if (b inside {[jse_pkg::LEAD3_LO:jse_pkg::LEAD3_HI]}) begin
                     held_in[0]  = b;
                     held_cnt_in = 2'd1;
                     seq_len_in  = 3'd3;
                     acc_in      = {17'd0, b[3:0]};
                  end else if (b inside {[jse_pkg::LEAD4_LO:jse_pkg::LEAD4_HI]}) begin
                     held_in[0]  = b;
                     held_cnt_in = 2'd1;
                     seq_len_in  = 3'd4;
                     acc_in      = {18'd0, b[2:0]};
                  end else begin
                     cmd.tail = jse_pkg::TAIL_HEX;
                  end
               end
            end
            jse_pkg::KIND_END: begin
               cmd.open_quote = !open_ff;
               cmd.held_n     = held_cnt_ff;
               cmd.held_hex   = 1'b1;
               cmd.tail       = jse_pkg::TAIL_CLOSE;
               open_in        = 1'b0;
               held_cnt_in    = 2'd0;
               seq_len_in     = 3'd0;
               acc_in         = '0;
            end
            jse_pkg::KIND_NULL: begin
               if (!open_ff) begin
                  cmd.tail = jse_pkg::TAIL_NULL;
               end
            end
            default: begin
               cmd.tail = jse_pkg::TAIL_NONE;
            end
         endcase
      end

      cmd_valid = accept && (cmd.open_quote || (cmd.held_n != 2'd0) ||
                             (cmd.tail != jse_pkg::TAIL_NONE));
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         open_ff     <= 1'b0;
         held_cnt_ff <= 2'd0;
         seq_len_ff  <= 3'd0;
         acc_ff      <= '0;
      end else begin
         open_ff     <= open_in;
         held_cnt_ff <= held_cnt_in;
         seq_len_ff  <= seq_len_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

// ===== hdl/jse_queue.sv =====
`timescale 1ns / 1ps

module jse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  jse_pkg::cmd_type  wr_cmd,
   input  logic              rd_en,
   output jse_pkg::cmd_type  rd_cmd,
   output logic              full,
   output logic              empty
);

   jse_pkg::cmd_type slot_ff [jse_pkg::QUEUE_DEPTH];

   logic [jse_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jse_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jse_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_wr, do_rd;

   always_comb begin
      full  = (count_ff == jse_pkg::QCNT_W'(jse_pkg::QUEUE_DEPTH));
      empty = (count_ff == '0);
      do_wr = wr_en && !full;
      do_rd = rd_en && !empty;

      rd_cmd = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == jse_pkg::QPTR_W'(jse_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : jse_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == jse_pkg::QPTR_W'(jse_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : jse_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/jse_back.sv =====
`timescale 1ns / 1ps

module jse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jse_pkg::cmd_type  head,
   output logic              head_pop,
   output logic              rsp_valid,
   output jse_pkg::rsp_type  rsp,
   input  logic              rsp_pop
);

   typedef enum logic [1:0] {
      PH_OPEN,
      PH_HELD,
      PH_TAIL
   } phase_type;

   phase_type         phase_ff, phase_in, ph;
   logic              started_ff;
   logic [1:0]        idx_ff, idx_in, idx;
   logic [2:0]        sub_ff, sub_in, sub;
   logic              rsp_valid_ff;
   jse_pkg::rsp_type  rsp_ff;

   logic              step;
   logic              done;
   logic              has_tail;
   logic [7:0]        cur_byte;

   always_comb begin
      has_tail = (head.tail != jse_pkg::TAIL_NONE);
      step     = head_valid && (!rsp_valid_ff || rsp_pop);

      if (started_ff) begin
         ph  = phase_ff;
         idx = idx_ff;
         sub = sub_ff;
      end else begin
         idx = 2'd0;
         sub = 3'd0;
         if (head.open_quote) begin
            ph = PH_OPEN;
         end else if (head.held_n != 2'd0) begin
            ph = PH_HELD;
         end else begin
            ph = PH_TAIL;
         end
      end

      cur_byte = jse_pkg::CH_QUOTE;
      done     = 1'b0;
      phase_in = ph;
      idx_in   = idx;
      sub_in   = 3'(sub + 3'd1);

      case (ph)
         PH_OPEN: begin
            cur_byte = jse_pkg::CH_QUOTE;
            sub_in   = 3'd0;
            if (head.held_n != 2'd0) begin
               phase_in = PH_HELD;
            end else if (has_tail) begin
               phase_in = PH_TAIL;
            end else begin
               done = 1'b1;
            end
         end
         PH_HELD: begin
            cur_byte = head.held_hex ? jse_pkg::hex_char(head.held[idx], sub) : head.held[idx];
            if (!head.held_hex || (sub == 3'd5)) begin
               sub_in = 3'd0;
               if (2'(idx + 2'd1) == head.held_n) begin
                  if (has_tail) begin
                     phase_in = PH_TAIL;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  idx_in = 2'(idx + 2'd1);
               end
            end
         end
         PH_TAIL: begin
            case (head.tail)
               jse_pkg::TAIL_RAW: cur_byte = head.tail_byte;
               jse_pkg::TAIL_ESC: cur_byte = (sub == 3'd0) ? jse_pkg::CH_BSLASH : head.tail_byte;
               jse_pkg::TAIL_HEX: cur_byte = jse_pkg::hex_char(head.tail_byte, sub);
               jse_pkg::TAIL_NULL: begin
                  case (sub)
                     3'd0:    cur_byte = jse_pkg::CH_N;
                     3'd1:    cur_byte = jse_pkg::CH_U;
                     default: cur_byte = jse_pkg::CH_L;
                  endcase
               end
               default: cur_byte = jse_pkg::CH_QUOTE;
            endcase
            done = (3'(sub + 3'd1) >= jse_pkg::tail_len(head.tail));
         end
         default: begin
            done = 1'b1;
         end
      endcase

      head_pop  = step && done;
      rsp_valid = rsp_valid_ff;
      rsp       = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff.out_byte    <= cur_byte;
         rsp_ff.last_of_run <= done;
         rsp_ff.string_done <= done && (ph == PH_TAIL) &&
                               ((head.tail == jse_pkg::TAIL_CLOSE) ||
                                (head.tail == jse_pkg::TAIL_NULL));
         phase_ff           <= phase_in;
         idx_ff             <= idx_in;
         sub_ff             <= sub_in;
      end
      if (reset) begin
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         started_ff   <= !done;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule
